[rtl/hrl_pkg.sv]
// Package for the hex record loader: parse phases, result kinds, status codes,
// the parse-state and result structs, and the hex digit decoder.
// Has no dependencies; used by hrl_parser and hex_record_loader_core.
package hrl_pkg;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_COUNT   = 7'b0000010,
    PH_ADDR_HI = 7'b0000100,
    PH_ADDR_LO = 7'b0001000,
    PH_TYPE    = 7'b0010000,
    PH_DATA    = 7'b0100000,
    PH_CSUM    = 7'b1000000
  } phase_e;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_LOADED    = 3'd0,
    ST_END       = 3'd1,
    ST_NO_RECORD = 3'd2,
    ST_BAD_HEX   = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_CHECKSUM  = 3'd5,
    ST_BAD_TYPE  = 3'd6
  } status_e;

  localparam logic [7:0]  RecordMark   = 8'h3A;
  localparam logic [7:0]  TypeData     = 8'h00;
  localparam logic [7:0]  TypeEnd      = 8'h01;
  localparam logic [15:0] LimitDefault = 16'h0100;
  localparam logic [7:0]  PageFill     = 8'hFF;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  hi;
    logic        pending;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [7:0]  kind;
    logic [7:0]  sum;
    logic [7:0]  offset;
  } parse_t;

  localparam parse_t ParseClear = '{
    phase: PH_HUNT, hi: 4'h0, pending: 1'b0, count: 8'h00,
    addr: 16'h0000, kind: 8'h00, sum: 8'h00, offset: 8'h00
  };

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [15:0] addr;
    logic [7:0]  data;
    status_e     status;
    logic [15:0] limit;
  } result_t;

  // Returns {digit_ok, value}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

[rtl/hrl_parser.sv]
// Record parser: holds the parse state, the halt flag, the page setting and
// the memory limit, and turns one character into at most one result.
// Depends on hrl_pkg.
module hrl_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             fire_i,
  input  logic [7:0]       ch_i,
  input  logic             eoi_i,
  output hrl_pkg::result_t res_o
);

  hrl_pkg::parse_t  ps_q, ps_d;
  logic             halted_q, halted_d;
  logic [7:0]       pages_q, pages_d;
  logic [15:0]      limit_q, limit_d;

  logic [4:0]       dec;
  logic [7:0]       byte_v;
  logic [7:0]       sum_new;
  logic [7:0]       offset_inc;
  logic [15:0]      top;
  hrl_pkg::result_t res;

  assign dec        = hrl_pkg::hex_decode(ch_i);
  assign byte_v     = {ps_q.hi, dec[3:0]};
  assign sum_new    = ps_q.sum + byte_v;
  assign offset_inc = ps_q.offset + 8'd1;
  assign top        = ps_q.addr + {8'h00, ps_q.count};

  always_comb begin
    ps_d       = ps_q;
    halted_d   = halted_q;
    pages_d    = pages_q;
    limit_d    = limit_q;
    res        = '0;
    res.kind   = hrl_pkg::KIND_STATUS;
    res.status = hrl_pkg::ST_LOADED;

    if (cfg_we_i) begin
      pages_d = cfg_wdata_i;
      limit_d = (cfg_wdata_i == 8'h00) ? hrl_pkg::LimitDefault
                                       : {cfg_wdata_i, hrl_pkg::PageFill};
    end

    if (fire_i) begin
      if (eoi_i) begin
        // End of input always resynchronizes; it reports only when running.
        ps_d     = hrl_pkg::ParseClear;
        halted_d = 1'b0;
        if (!halted_q) begin
          res.valid  = 1'b1;
          res.status = (ps_q.phase != hrl_pkg::PH_HUNT) ? hrl_pkg::ST_TRUNCATED
                                                        : hrl_pkg::ST_NO_RECORD;
        end
      end else if (halted_q) begin
        ps_d = ps_q;
      end else if (ps_q.phase == hrl_pkg::PH_HUNT) begin
        if (ch_i == hrl_pkg::RecordMark) begin
          ps_d       = hrl_pkg::ParseClear;
          ps_d.phase = hrl_pkg::PH_COUNT;
        end
      end else if (!dec[4]) begin
        ps_d       = hrl_pkg::ParseClear;
        halted_d   = 1'b1;
        res.valid  = 1'b1;
        res.status = hrl_pkg::ST_BAD_HEX;
      end else if (!ps_q.pending) begin
        ps_d.hi      = dec[3:0];
        ps_d.pending = 1'b1;
      end else begin
        ps_d.pending = 1'b0;
        ps_d.sum     = sum_new;
        case (ps_q.phase)
          hrl_pkg::PH_COUNT: begin
            ps_d.count = byte_v;
            ps_d.phase = hrl_pkg::PH_ADDR_HI;
          end
          hrl_pkg::PH_ADDR_HI: begin
            ps_d.addr  = {byte_v, 8'h00};
            ps_d.phase = hrl_pkg::PH_ADDR_LO;
          end
          hrl_pkg::PH_ADDR_LO: begin
            ps_d.addr  = {ps_q.addr[15:8], byte_v};
            ps_d.phase = hrl_pkg::PH_TYPE;
          end
          hrl_pkg::PH_TYPE: begin
            ps_d.kind   = byte_v;
            ps_d.offset = 8'h00;
            ps_d.phase  = (ps_q.count == 8'h00) ? hrl_pkg::PH_CSUM : hrl_pkg::PH_DATA;
          end
          hrl_pkg::PH_DATA: begin
            res.valid   = 1'b1;
            res.kind    = hrl_pkg::KIND_WRITE;
            res.addr    = ps_q.addr + {8'h00, ps_q.offset};
            res.data    = byte_v;
            ps_d.offset = offset_inc;
            if (offset_inc == ps_q.count) begin
              ps_d.phase = hrl_pkg::PH_CSUM;
            end
          end
          hrl_pkg::PH_CSUM: begin
            res.valid = 1'b1;
            if (sum_new != 8'h00) begin
              res.status = hrl_pkg::ST_CHECKSUM;
            end else if (ps_q.kind == hrl_pkg::TypeEnd) begin
              res.status = hrl_pkg::ST_END;
            end else if (ps_q.kind != hrl_pkg::TypeData) begin
              res.status = hrl_pkg::ST_BAD_TYPE;
            end else if (ps_q.count == 8'h00) begin
              res.status = hrl_pkg::ST_END;
            end else begin
              res.status = hrl_pkg::ST_LOADED;
              if (pages_q == 8'h00 && top > limit_q) begin
                limit_d = top;
              end
            end
            ps_d     = hrl_pkg::ParseClear;
            halted_d = (res.status != hrl_pkg::ST_LOADED);
          end
          default: begin
            ps_d = hrl_pkg::ParseClear;
          end
        endcase
      end
    end

    res.limit = limit_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q     <= hrl_pkg::ParseClear;
      halted_q <= 1'b0;
      pages_q  <= 8'h00;
      limit_q  <= hrl_pkg::LimitDefault;
    end else begin
      ps_q     <= ps_d;
      halted_q <= halted_d;
      pages_q  <= pages_d;
      limit_q  <= limit_d;
    end
  end

  // A halted parser always sits in the hunting phase.
  a_halt_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> ps_q.phase == hrl_pkg::PH_HUNT)
    else $error("halted parser left the hunting phase");

  // While hunting, no half-read byte or partial sum survives.
  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ps_q.phase == hrl_pkg::PH_HUNT |-> !ps_q.pending && ps_q.sum == 8'h00)
    else $error("stale record state while hunting");

  // A nonzero page write with no request parsed sets the limit to {page, 0xFF} on the next cycle.
  a_cfg_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_wdata_i != 8'h00 && !fire_i |=>
      limit_q == {$past(cfg_wdata_i), hrl_pkg::PageFill})
    else $error("limit not reloaded after page write");

endmodule

[rtl/hex_record_loader_core.sv]
// Top level of the hex record loader: input register, record parser and
// result register with valid/stall handshakes on both sides.
// Depends on hrl_pkg and hrl_parser.
//
// Usage: one character request enters on ch_i / end_of_input_i with
// in_valid_i, and is taken at an edge where in_stall_o is low. Each request
// yields zero or one result on out_valid_o: a memory write (kind 0, address
// and data) or a record status (kind 1, status code); memory_limit_o comes
// with both. A taken request is parsed out of the input register, and its
// result is loaded into the result register when that register can load.
// The block takes one request per cycle while no result is held by
// out_stall_i, with a single register stage on each side of the parser.
// When out_stall_i holds a result, the input register keeps one request and
// then raises in_stall_o. The page register is written with cfg_we_i and
// cfg_wdata_i while the block is idle; it reloads the memory limit at once.
// Reset empties both registers, clears the parse state and halt flag, sets the
// page count to zero and the limit to 0x0100.
module hex_record_loader_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [15:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic [2:0]  status_o,
  output logic [15:0] memory_limit_o
);

  logic             in_valid_q;
  logic [7:0]       ch_q;
  logic             eoi_q;
  logic             out_valid_q;
  hrl_pkg::result_t out_q;
  hrl_pkg::result_t res;
  logic             advance;
  logic             fire;

  // The result register can load when it is empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ch_q  <= ch_i;
      eoi_q <= end_of_input_i;
    end
  end

  hrl_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .ch_i        (ch_q),
    .eoi_i       (eoi_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign write_address_o = out_q.addr;
  assign write_data_o    = out_q.data;
  assign status_o        = out_q.status;
  assign memory_limit_o  = out_q.limit;

  // The input side only backs up behind a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A write result never carries a status code.
  a_write_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == hrl_pkg::KIND_WRITE |->
      out_q.status == hrl_pkg::ST_LOADED)
    else $error("write result with nonzero status");

  // A parsed request that makes a result is in the result register next cycle.
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res.valid |=> out_valid_q)
    else $error("result lost between parser and result register");

endmodule

[sim/hrl_load_checker.sv]
`timescale 1ns / 100ps
// Checker for the hex record loader: watches the request, result and page
// register ports, predicts every result and compares it field by field.
// Depends on hrl_pkg for the phase, kind and status codes.
module hrl_load_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  ch_i,
  input  logic        end_of_input_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [15:0] write_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] memory_limit_i,
  output int          fail_count_o = 0,
  output int          pending_o = 0
);

  typedef struct packed {
    hrl_pkg::kind_e   kind;
    logic [15:0]      addr;
    logic [7:0]       data;
    hrl_pkg::status_e status;
    logic [15:0]      limit;
  } load_result_t;

  load_result_t expected_q[$];

  // Predicted parser state.
  logic [7:0]      pages;
  hrl_pkg::phase_e phase;
  logic [3:0]      hi_nib;
  logic            nib_pend;
  logic [7:0]      rec_count;
  logic [15:0]     rec_addr;
  logic [7:0]      rec_type;
  logic [7:0]      rec_sum;
  logic [7:0]      offset;
  logic [15:0]     limit;
  logic            halted;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  task automatic clear_record();
    phase    = hrl_pkg::PH_HUNT;
    hi_nib   = '0;
    nib_pend = 1'b0;
    rec_count = '0;
    rec_addr = '0;
    rec_type = '0;
    rec_sum  = '0;
    offset   = '0;
  endtask

  task automatic reload_limit();
    limit = (pages == 8'd0) ? hrl_pkg::LimitDefault : {pages, hrl_pkg::PageFill};
  endtask

  task automatic push_status(input hrl_pkg::status_e st);
    load_result_t r;
    r.kind   = hrl_pkg::KIND_STATUS;
    r.addr   = '0;
    r.data   = '0;
    r.status = st;
    r.limit  = limit;
    expected_q.push_back(r);
  endtask

  task automatic close_record();
    hrl_pkg::status_e st;
    logic [15:0]      rec_end;
    rec_end = rec_addr + {8'h00, rec_count};
    if (rec_sum != 8'd0) begin
      st = hrl_pkg::ST_CHECKSUM;
    end else if (rec_type == hrl_pkg::TypeEnd) begin
      st = hrl_pkg::ST_END;
    end else if (rec_type != hrl_pkg::TypeData) begin
      st = hrl_pkg::ST_BAD_TYPE;
    end else if (rec_count == 8'd0) begin
      st = hrl_pkg::ST_END;
    end else begin
      st = hrl_pkg::ST_LOADED;
      if (pages == 8'd0 && limit < rec_end) limit = rec_end;
    end
    clear_record();
    if (st != hrl_pkg::ST_LOADED) halted = 1'b1;
    push_status(st);
  endtask

  task automatic predict_request(input logic [7:0] c, input logic eoi);
    load_result_t r;
    int           nib;
    logic [7:0]   b;
    logic         was_halted;
    logic         in_record;
    if (eoi) begin
      was_halted = halted;
      in_record  = (phase != hrl_pkg::PH_HUNT);
      clear_record();
      halted = 1'b0;
      if (!was_halted) begin
        push_status(in_record ? hrl_pkg::ST_TRUNCATED : hrl_pkg::ST_NO_RECORD);
      end
      return;
    end
    if (halted) return;
    if (phase == hrl_pkg::PH_HUNT) begin
      if (c == hrl_pkg::RecordMark) begin
        clear_record();
        phase = hrl_pkg::PH_COUNT;
      end
      return;
    end
    nib = nibble_of(c);
    if (nib < 0) begin
      clear_record();
      halted = 1'b1;
      push_status(hrl_pkg::ST_BAD_HEX);
      return;
    end
    if (!nib_pend) begin
      hi_nib   = nib[3:0];
      nib_pend = 1'b1;
      return;
    end
    b        = {hi_nib, nib[3:0]};
    nib_pend = 1'b0;
    rec_sum  = rec_sum + b;
    case (phase)
      hrl_pkg::PH_COUNT: begin
        rec_count = b;
        phase     = hrl_pkg::PH_ADDR_HI;
      end
      hrl_pkg::PH_ADDR_HI: begin
        rec_addr = {b, 8'h00};
        phase    = hrl_pkg::PH_ADDR_LO;
      end
      hrl_pkg::PH_ADDR_LO: begin
        rec_addr[7:0] = b;
        phase         = hrl_pkg::PH_TYPE;
      end
      hrl_pkg::PH_TYPE: begin
        rec_type = b;
        offset   = '0;
        phase    = (rec_count == 8'd0) ? hrl_pkg::PH_CSUM : hrl_pkg::PH_DATA;
      end
      hrl_pkg::PH_DATA: begin
        r.kind   = hrl_pkg::KIND_WRITE;
        r.addr   = rec_addr + {8'h00, offset};
        r.data   = b;
        r.status = hrl_pkg::ST_LOADED;
        r.limit  = limit;
        expected_q.push_back(r);
        offset = offset + 8'd1;
        if (offset == rec_count) phase = hrl_pkg::PH_CSUM;
      end
      default: begin
        close_record();
      end
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, field, got, want);
    fail_count_o++;
  endtask

  task automatic check_result();
    load_result_t e;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result, kind", kind_i, 16'h0);
      return;
    end
    e = expected_q.pop_front();
    if (kind_i !== e.kind) report_mismatch("kind", kind_i, e.kind);
    if (write_address_i !== e.addr) report_mismatch("write_address", write_address_i, e.addr);
    if (write_data_i !== e.data) report_mismatch("write_data", write_data_i, e.data);
    if (status_i !== e.status) report_mismatch("status", status_i, e.status);
    if (memory_limit_i !== e.limit) report_mismatch("memory_limit", memory_limit_i, e.limit);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      pages  = '0;
      halted = 1'b0;
      clear_record();
      reload_limit();
      pending_o = 0;
    end else begin
      // A result can never belong to a request taken at the same edge, so
      // results are checked before the new request is predicted.
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_we_i) begin
        pages = cfg_wdata_i;
        reload_limit();
      end
      if (in_valid_i && !in_stall_i) predict_request(ch_i, end_of_input_i);
      pending_o = expected_q.size();
    end
  end

endmodule

[sim/tb_hex_record_loader_core.sv]
`timescale 1ns / 100ps
// Testbench top for hex_record_loader_core: clock, reset, character streams
// of well-formed and broken records, page settings and the final verdict.
// Depends on hrl_pkg, hex_record_loader_core and hrl_load_checker.
module tb_hex_record_loader_core;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_HEX, FLAW_CUT} flaw_e;

  localparam int TotalChars = 1950;
  localparam int QuietFrom  = 1800;
  localparam int HoldAt     = 600;
  localparam int HoldCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i = '0;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [15:0] write_address_o;
  logic [7:0]  write_data_o;
  logic [2:0]  status_o;
  logic [15:0] memory_limit_o;

  int fails;
  int pending;
  int sent = 0;
  bit quiet = 1'b0;
  bit held_off = 1'b0;

  always #4 clk_i = ~clk_i;

  hex_record_loader_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o, .ch_i,
    .end_of_input_i, .out_valid_o, .out_stall_i, .kind_o, .write_address_o,
    .write_data_o, .status_o, .memory_limit_o
  );

  hrl_load_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .ch_i, .end_of_input_i,
    .out_valid_i(out_valid_o), .out_stall_i, .kind_i(kind_o),
    .write_address_i(write_address_o), .write_data_i(write_data_o),
    .status_i(status_o), .memory_limit_i(memory_limit_o),
    .fail_count_o(fails), .pending_o(pending)
  );

  // Offers one request and returns at the falling edge after it is taken.
  task automatic send_item(input logic [7:0] c, input logic eoi);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    ch_i           <= c;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent++;
    if (sent >= QuietFrom) quiet = 1'b1;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "A" : "a";
    if (n < 4'd10) return "0" + 8'(n);
    return base + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == hrl_pkg::RecordMark);
    return c;
  endfunction

  // Any byte outside 0-9, A-F and a-f, colon and line ends included.
  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h00, 8'h2F));
      1: return 8'($urandom_range(8'h3A, 8'h40));
      2: return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  task automatic send_record(input logic [7:0] cnt, input logic [15:0] adr,
                             input logic [7:0] typ, input flaw_e flaw);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         nchars;
    int         cut;
    bytes = {cnt, adr[15:8], adr[7:0], typ};
    repeat (cnt) bytes.push_back(8'($urandom));
    sum = '0;
    foreach (bytes[i]) sum = sum + bytes[i];
    sum = 8'd0 - sum;
    if (flaw == FLAW_SUM) sum = sum + 8'($urandom_range(1, 255));
    bytes.push_back(sum);
    nchars = 1 + 2 * bytes.size();
    cut = (flaw == FLAW_HEX || flaw == FLAW_CUT) ? $urandom_range(1, nchars - 1) : nchars;
    for (int k = 0; k < nchars; k++) begin
      if (k == cut) begin
        if (flaw == FLAW_HEX) send_item(non_hex_char(), 1'b0);
        else send_item(8'($urandom), 1'b1);
        return;
      end
      if (k == 0) begin
        send_item(hrl_pkg::RecordMark, 1'b0);
      end else begin
        b = bytes[(k - 1) / 2];
        send_item(hex_char(((k - 1) % 2 == 0) ? b[7:4] : b[3:0]), 1'b0);
      end
    end
  endtask

  // One stream: a few records, then the end of input, at times after an end record.
  task automatic send_stream();
    int          roll;
    bit          stopped;
    logic [7:0]  cnt;
    logic [15:0] adr;
    stopped = 1'b0;
    repeat ($urandom_range(1, 6)) begin
      if (!stopped) begin
        repeat ($urandom_range(0, 3)) send_item(junk_char(), 1'b0);
        cnt = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(17, 255))
                                           : 8'($urandom_range(1, 16));
        adr = ($urandom_range(0, 3) == 0) ? 16'hFFF0 + 16'($urandom_range(0, 15))
                                          : 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          send_record(cnt, adr, hrl_pkg::TypeData, FLAW_NONE);
          if ($urandom_range(0, 1) == 1) begin
            send_item(8'h0D, 1'b0);
            send_item(8'h0A, 1'b0);
          end
        end else begin
          stopped = 1'b1;
          if (roll < 76) send_record(cnt, adr, hrl_pkg::TypeData, FLAW_SUM);
          else if (roll < 82) send_record(cnt, adr, hrl_pkg::TypeData, FLAW_HEX);
          else if (roll < 88) send_record(cnt, adr, hrl_pkg::TypeData, FLAW_CUT);
          else if (roll < 92) send_record(cnt, adr, 8'($urandom_range(2, 255)), FLAW_NONE);
          else if (roll < 96) send_record(8'd0, adr, hrl_pkg::TypeData, FLAW_NONE);
          else send_record(cnt, adr, hrl_pkg::TypeEnd, FLAW_NONE);
          // Characters after a halt are dropped until the end of input.
          repeat ($urandom_range(0, 1)) send_item(8'($urandom), 1'b0);
          send_item(8'($urandom), 1'b1);
        end
      end
    end
    if (!stopped) begin
      if ($urandom_range(0, 1) == 1) begin
        send_record(8'd0, 16'($urandom), hrl_pkg::TypeEnd, FLAW_NONE);
      end
      send_item(8'($urandom), 1'b1);
    end
  endtask

  // Writes the page register once every expected result is in and the
  // parser has had time to take up the last request.
  task automatic set_pages(input logic [7:0] p);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stall bursts, calm stretches and one long hold-off.
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (!held_off && sent >= HoldAt) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            out_stall_i <= 1'b0;
            repeat (60) @(negedge clk_i);
          end
          1, 2, 3: begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk_i);
            out_stall_i <= 1'b0;
          end
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    logic [7:0] page_plan[5];
    page_plan = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd0};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening: end of input while hunting, extreme bytes skipped,
    // a colon inside a record, a dropped character while halted, a cut-off
    // record and an end record.
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(hrl_pkg::RecordMark, 1'b0);
    send_item(hrl_pkg::RecordMark, 1'b0);
    send_item("x", 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(hrl_pkg::RecordMark, 1'b0);
    send_item("0", 1'b0);
    send_item(8'hFF, 1'b1);
    send_record(8'd0, 16'h0000, hrl_pkg::TypeEnd, FLAW_NONE);
    send_item(8'h00, 1'b1);

    foreach (page_plan[p]) begin
      set_pages(page_plan[p]);
      while (sent < (p + 1) * TotalChars / 5) send_stream();
    end

    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (10) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[hex_record_loader_core.f]
rtl/hrl_pkg.sv
rtl/hrl_parser.sv
rtl/hex_record_loader_core.sv
sim/hrl_load_checker.sv
sim/tb_hex_record_loader_core.sv
